### rtl/csbd_pkg.sv
// Package for the counter-selected byte descrambler.
// Holds item codes, reset values and the per-method XOR masks and bit orders.
// No dependencies; used by the channel interfaces and all rtl modules.
package csbd_pkg;

   typedef enum logic {
      KIND_PORT  = 1'b0,
      KIND_FETCH = 1'b1
   } kind_type;

   typedef logic [3:0] counter_type;
   typedef logic [1:0] method_type;
   typedef logic [2:0] bit_sel_type;
   typedef logic [7:0] byte_type;

   localparam counter_type COUNTER_RESET = 4'hA;
   localparam method_type  METHOD_RESET  = 2'd2;
   localparam counter_type COUNTER_MASK  = 4'hF;

   // window in which the counter selects a method: 8..11, i.e. top bits 2'b10
   localparam logic [1:0] WINDOW_TOP = 2'b10;

   localparam byte_type XOR_MASK [4] = '{8'hFC, 8'hF6, 8'h7D, 8'h77};

   localparam bit_sel_type BIT_ORDER [4][8] = '{
      '{3'd3, 3'd7, 3'd0, 3'd6, 3'd4, 3'd1, 3'd2, 3'd5},
      '{3'd1, 3'd7, 3'd0, 3'd3, 3'd4, 3'd6, 3'd2, 3'd5},
      '{3'd3, 3'd0, 3'd4, 3'd6, 3'd7, 3'd1, 3'd2, 3'd5},
      '{3'd1, 3'd0, 3'd4, 3'd3, 3'd7, 3'd6, 3'd2, 3'd5}
   };

endpackage

### rtl/csbd_channels.sv
// Valid/ready channel interfaces for the descrambler request and response items.
// Depends on csbd_pkg for the payload types.
interface csbd_req_if import csbd_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        kind;
   logic        step_down;
   byte_type    raw_byte;

   modport source (output valid, output kind, output step_down, output raw_byte,
                   input ready);
   modport sink   (input valid, input kind, input step_down, input raw_byte,
                   output ready);
endinterface

interface csbd_rsp_if import csbd_pkg::*; ();
   logic        valid;
   logic        ready;
   byte_type    data;
   logic        bad_counter;
   method_type  method;

   modport source (output valid, output data, output bad_counter, output method,
                   input ready);
   modport sink   (input valid, input data, input bad_counter, input method,
                   output ready);
endinterface

### rtl/csbd_unscramble.sv
// Combinational byte descramble: XOR with the method mask, then bit permutation.
// Depends on csbd_pkg for the mask and bit-order tables.
module csbd_unscramble import csbd_pkg::*; (
   input  byte_type   raw_byte,
   input  method_type method,
   output byte_type   data
);

   byte_type masked;

   assign masked = raw_byte ^ XOR_MASK[method];

   always_comb begin
      data = '0;
      for (int k = 0; k < 8; k++) begin
         data[3'(7 - k)] = masked[BIT_ORDER[method][k]];
      end
   end

endmodule

### rtl/counter_selected_byte_descrambler_core.sv
// Counter-selected byte descrambler. A port item steps a 4-bit up/down counter
// (reset 10); while the count is 8..11 its low bits pick one of four methods (reset 2),
// else bad_counter is flagged. A fetch item is XORed and bit-permuted by the method in
// force. One item per cycle is sustained while rsp_chan is ready; each passes from acceptance
// to response through an input register, then a result register, and the counter update sits in the
// single stage between them. Depends on csbd_pkg, csbd_channels and csbd_unscramble.
module counter_selected_byte_descrambler_core import csbd_pkg::*; (
   input logic         clock,
   input logic         reset,
   csbd_req_if.sink    req_chan,
   csbd_rsp_if.source  rsp_chan
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff;
   logic        s1_down_ff;
   byte_type    s1_raw_ff;

   logic        out_valid_ff, out_valid_in;
   byte_type    out_data_ff;
   logic        out_bad_ff;
   method_type  out_method_ff;

   counter_type counter_ff, counter_in;
   method_type  method_ff, method_in;

   logic        out_advance;
   logic        s1_fire;
   logic        req_fire;
   logic        bad_now;
   byte_type    fetch_data;

   assign out_advance = !out_valid_ff || rsp_chan.ready;
   assign s1_fire     = s1_valid_ff && out_advance;
   assign req_fire    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || out_advance;

   csbd_unscramble u_unscramble (
      .raw_byte (s1_raw_ff),
      .method   (method_ff),
      .data     (fetch_data)
   );

   always_comb begin
      counter_in = counter_ff;
      method_in  = method_ff;
      bad_now    = 1'b0;
      if (s1_fire && s1_kind_ff == KIND_PORT) begin
         counter_in = s1_down_ff ? counter_ff + COUNTER_MASK : counter_ff + 4'd1;
         if (counter_in[3:2] == WINDOW_TOP) begin
            method_in = counter_in[1:0];
         end else begin
            bad_now = 1'b1;
         end
      end
   end

   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_advance);
   assign out_valid_in = s1_fire || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         counter_ff   <= COUNTER_RESET;
         method_ff    <= METHOD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         counter_ff   <= counter_in;
         method_ff    <= method_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_chan.kind;
         s1_down_ff <= req_chan.step_down;
         s1_raw_ff  <= req_chan.raw_byte;
      end
      if (s1_fire) begin
         out_data_ff   <= (s1_kind_ff == KIND_FETCH) ? fetch_data : '0;
         out_bad_ff    <= bad_now;
         out_method_ff <= method_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.data        = out_data_ff;
   assign rsp_chan.bad_counter = out_bad_ff;
   assign rsp_chan.method      = out_method_ff;

   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> counter_ff == COUNTER_RESET && method_ff == METHOD_RESET)
      else $error("state not at reset values after reset");

   a_method_tracks_window: assert property (@(posedge clock) disable iff (reset)
      counter_ff[3:2] == WINDOW_TOP |-> method_ff == counter_ff[1:0])
      else $error("method disagrees with counter inside window");

   a_state_only_on_port: assert property (@(posedge clock) disable iff (reset)
      !(s1_fire && s1_kind_ff == KIND_PORT) |=> $stable(counter_ff) && $stable(method_ff))
      else $error("state moved without a port item");

   a_port_steps_counter: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_kind_ff == KIND_PORT |=> counter_ff != $past(counter_ff))
      else $error("port item did not step the counter");

   a_bad_has_zero_data: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_bad_ff |-> out_data_ff == '0)
      else $error("bad_counter response carries data");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for counter_selected_byte_descrambler_core: directed then random items.
// A class predicts each response from the accepted requests. Needs csbd_pkg and csbd_channels.
module tb_top import csbd_pkg::*; ();

   typedef struct {
      byte_type   data;
      logic       bad_counter;
      method_type method;
   } plain_rsp_type;

   class plaintext_ledger;
      counter_type   counter;
      method_type    method;
      plain_rsp_type plain_due [$];
      int            mismatches;
      int            port_steps;
      int            off_window;
      int            fetches [4];

      function new();
         counter = COUNTER_RESET;
         method  = METHOD_RESET;
      endfunction

      function byte_type unscramble_byte(byte_type raw, method_type sel);
         byte_type mixed;
         byte_type plain;
         mixed = raw ^ XOR_MASK[sel];
         for (int k = 0; k < 8; k++)
            plain[7 - k] = mixed[BIT_ORDER[sel][k]];
         return plain;
      endfunction

      function void note_request(kind_type kind, logic step_down, byte_type raw);
         plain_rsp_type want;
         want.data        = '0;
         want.bad_counter = 1'b0;
         if (kind == KIND_FETCH) begin
            want.data = unscramble_byte(raw, method);
            fetches[method]++;
         end else begin
            counter = step_down ? counter - 4'd1 : counter + 4'd1;
            port_steps++;
            if (counter[3:2] == WINDOW_TOP) begin
               method = counter[1:0];
            end else begin
               want.bad_counter = 1'b1;
               off_window++;
            end
         end
         want.method = method;
         plain_due.push_back(want);
      endfunction

      function void check_response(byte_type data, logic bad_counter, method_type got_method);
         plain_rsp_type want;
         if (plain_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: response with nothing outstanding: data=%h bad=%b method=%0d",
                        $realtime, data, bad_counter, got_method);
            return;
         end
         want = plain_due.pop_front();
         if (data !== want.data || bad_counter !== want.bad_counter
             || got_method !== want.method) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: data %h/%h bad_counter %b/%b method %0d/%0d (expected/actual)",
                        $realtime, want.data, data, want.bad_counter, bad_counter,
                        want.method, got_method);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   bit   long_hold_done;
   int   hold_left;
   int   idle_cycles;

   csbd_req_if req_if ();
   csbd_rsp_if rsp_if ();

   plaintext_ledger ledger = new();

   counter_selected_byte_descrambler_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic drive_item(kind_type kind, logic step_down, byte_type raw);
      req_if.valid     <= 1'b1;
      req_if.kind      <= kind;
      req_if.step_down <= step_down;
      req_if.raw_byte  <= raw;
      do @(posedge clock); while (!req_if.ready);
      ledger.note_request(kind, step_down, raw);
   endtask

   task automatic idle_gap();
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   // sender
   initial begin
      logic        down;
      counter_type cnt;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.kind      <= KIND_PORT;
      req_if.step_down <= 1'b0;
      req_if.raw_byte  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      drive_item(KIND_FETCH, 1'b0, 8'h00);
      drive_item(KIND_FETCH, 1'b1, 8'hFF);
      drive_item(KIND_PORT,  1'b0, 8'hFF);
      drive_item(KIND_FETCH, 1'b0, 8'h00);
      drive_item(KIND_FETCH, 1'b0, 8'hFF);
      repeat (5) drive_item(KIND_PORT, 1'b0, 8'h00);
      drive_item(KIND_PORT,  1'b1, 8'hA5);
      drive_item(KIND_FETCH, 1'b1, 8'h5A);
      repeat (4) drive_item(KIND_PORT, 1'b1, 8'h3C);
      drive_item(KIND_PORT,  1'b1, 8'h00);
      drive_item(KIND_PORT,  1'b1, 8'h00);
      drive_item(KIND_FETCH, 1'b0, 8'h00);
      drive_item(KIND_FETCH, 1'b0, 8'hFF);
      drive_item(KIND_PORT,  1'b1, 8'hC3);
      drive_item(KIND_FETCH, 1'b1, 8'h00);
      drive_item(KIND_FETCH, 1'b0, 8'hFF);
      drive_item(KIND_PORT,  1'b1, 8'h00);
      drive_item(KIND_FETCH, 1'b0, 8'hA5);

      for (int i = 0; i < 2000; i++) begin
         quiet = (i >= 1700);
         if ($urandom_range(0, 9) < 6) begin
            drive_item(KIND_FETCH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            cnt = ledger.counter;
            // steer the count back towards the method window most of the time
            if ($urandom_range(0, 4) == 0 || (cnt >= 8 && cnt <= 11))
               down = 1'($urandom_range(0, 1));
            else
               down = (cnt >= 12);
            drive_item(KIND_PORT, down, 8'($urandom_range(0, 255)));
         end
         if (!quiet && $urandom_range(0, 7) == 0)
            idle_gap();
      end
      req_if.valid <= 1'b0;

      while (ledger.plain_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d port steps (%0d outside the window) and %0d fetches",
               ledger.port_steps, ledger.off_window,
               ledger.fetches[0] + ledger.fetches[1] + ledger.fetches[2] + ledger.fetches[3]);
      $display("fetches per method: %0d %0d %0d %0d, mismatches %0d",
               ledger.fetches[0], ledger.fetches[1], ledger.fetches[2], ledger.fetches[3],
               ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.plain_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // receiver
   initial begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready)
            ledger.check_response(rsp_if.data, rsp_if.bad_counter, rsp_if.method);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (!long_hold_done && ledger.port_steps + ledger.fetches[0] >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 300;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 16) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 5000) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule

### counter_selected_byte_descrambler_core.f
rtl/csbd_pkg.sv
rtl/csbd_channels.sv
rtl/csbd_unscramble.sv
rtl/counter_selected_byte_descrambler_core.sv
tb/tb_top.sv
